FILE: rtl/core/srpq_pkg.sv
package srpq_pkg;

  // Operation codes on in_operation.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Status codes on out_status.
  typedef logic [1:0] status_t;
  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_REMOVED  = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  // One stored entry.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] prio;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_DEL  = 4'b1000
  } state_t;

endpackage

FILE: rtl/core/sorted_ring_priority_queue.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   in_operation, in_entry_value, in_entry_priority
// out      output     out_valid/out_ready out_status, out_removed_value, out_removed_priority,
//                                         out_occupancy
//
// An insert into a full queue or a delete from an empty queue is answered from idle, without the store.
// A delete makes one registered read of the entry store at the head.
// An insert moves entries one slot toward the tail until the new one comes to rest;
// each move is one read and one compare-and-write on the store.
// Reset (rst_n low, synchronous) empties the queue; store contents are not cleared.
// A result waiting on out_ready holds; a new transaction is taken in the cycle it drains.
module sorted_ring_priority_queue #(
  parameter int CAPACITY = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_entry_value,
  input  logic [7:0] in_entry_priority,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_removed_value,
  output logic [7:0] out_removed_priority,
  output logic [3:0] out_occupancy
);

  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  srpq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  srpq_pkg::entry_t new_r, new_nxt;

  srpq_pkg::entry_t mem_r [CAPACITY];
  srpq_pkg::entry_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  srpq_pkg::entry_t mem_wd;

  logic out_valid_r, out_valid_nxt;
  srpq_pkg::status_t status_r, status_nxt;
  srpq_pkg::entry_t removed_r, removed_nxt;
  logic [3:0] occ_r, occ_nxt;

  logic accept;
  logic [AW-1:0] slot_prev, tail_next, head_next;

  assign in_ready = (state_r == srpq_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept = in_valid && in_ready;

  assign slot_prev = (slot_r == '0) ? LAST_SLOT : slot_r - 1'b1;
  assign tail_next = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
  assign head_next = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;

  // In idle the head is read so that a delete has its entry in the next cycle.
  assign rd_addr = (state_r == srpq_pkg::S_IDLE) ? head_r : slot_prev;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    count_nxt = count_r;
    slot_nxt = slot_r;
    walk_nxt = walk_r;
    new_nxt = new_r;
    mem_we = 1'b0;
    mem_wa = slot_r;
    mem_wd = new_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt = status_r;
    removed_nxt = removed_r;
    occ_nxt = occ_r;

    unique case (state_r)
      srpq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_operation == srpq_pkg::OP_INSERT) begin
            if (count_r == FULL_COUNT) begin
              out_valid_nxt = 1'b1;
              status_nxt = srpq_pkg::ST_FULL;
              removed_nxt = '0;
              occ_nxt = 4'(count_r);
            end else begin
              tail_nxt = tail_next;
              count_nxt = count_r + 1'b1;
              slot_nxt = tail_next;
              walk_nxt = count_r + 1'b1;
              new_nxt.value = in_entry_value;
              new_nxt.prio = in_entry_priority;
              state_nxt = srpq_pkg::S_READ;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt = srpq_pkg::ST_EMPTY;
              removed_nxt = '0;
              occ_nxt = 4'(count_r);
            end else begin
              head_nxt = head_next;
              count_nxt = count_r - 1'b1;
              state_nxt = srpq_pkg::S_DEL;
            end
          end
        end
      end
      srpq_pkg::S_READ: begin
        // The new entry stays in new_r and is written only where it comes to rest.
        if (walk_r <= CW'(1)) begin
          mem_we = 1'b1;
          out_valid_nxt = 1'b1;
          status_nxt = srpq_pkg::ST_INSERTED;
          removed_nxt = '0;
          occ_nxt = 4'(count_r);
          state_nxt = srpq_pkg::S_IDLE;
        end else begin
          state_nxt = srpq_pkg::S_CMP;
        end
      end
      srpq_pkg::S_CMP: begin
        mem_we = 1'b1;
        if (new_r.prio < rd_data_r.prio) begin
          mem_wd = rd_data_r;
          slot_nxt = slot_prev;
          walk_nxt = walk_r - 1'b1;
          state_nxt = srpq_pkg::S_READ;
        end else begin
          out_valid_nxt = 1'b1;
          status_nxt = srpq_pkg::ST_INSERTED;
          removed_nxt = '0;
          occ_nxt = 4'(count_r);
          state_nxt = srpq_pkg::S_IDLE;
        end
      end
      srpq_pkg::S_DEL: begin
        out_valid_nxt = 1'b1;
        status_nxt = srpq_pkg::ST_REMOVED;
        removed_nxt = rd_data_r;
        occ_nxt = 4'(count_r);
        state_nxt = srpq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = srpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srpq_pkg::S_IDLE;
      head_r <= '0;
      tail_r <= LAST_SLOT;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    walk_r <= walk_nxt;
    new_r <= new_nxt;
    status_r <= status_nxt;
    removed_r <= removed_nxt;
    occ_r <= occ_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_removed_value = removed_r.value;
  assign out_removed_priority = removed_r.prio;
  assign out_occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count exceeds capacity");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srpq_pkg::S_READ || state_r == srpq_pkg::S_CMP) |-> walk_r <= count_r)
    else $error("insert walk longer than queue");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srpq_pkg::S_CMP) |-> $past(state_r) == srpq_pkg::S_READ)
    else $error("compare step without a preceding read");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == srpq_pkg::OP_INSERT && count_r != FULL_COUNT)
      |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted insert did not grow the queue");

endmodule
